[rtl/core/lr35902_opcode_row0_executor_macros.svh]
// assertion macros for the row-0 instruction executor
`ifndef LR35902_OPCODE_ROW0_EXECUTOR_MACROS_SVH
`define LR35902_OPCODE_ROW0_EXECUTOR_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define LR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lr35r0_pkg.sv]
// shared types and opcode constants for the row-0 instruction executor
`timescale 1ns / 1ps

package lr35r0_pkg;

    localparam logic [7:0] OPC_NOP       = 8'h00;
    localparam logic [7:0] OPC_LD_BC_NN  = 8'h01;
    localparam logic [7:0] OPC_ST_BC_A   = 8'h02;
    localparam logic [7:0] OPC_INC_BC    = 8'h03;
    localparam logic [7:0] OPC_INC_B     = 8'h04;
    localparam logic [7:0] OPC_DEC_B     = 8'h05;
    localparam logic [7:0] OPC_LD_B_N    = 8'h06;
    localparam logic [7:0] OPC_RLCA      = 8'h07;
    localparam logic [7:0] OPC_ST_NN_SP  = 8'h08;
    localparam logic [7:0] OPC_ADD_HL_BC = 8'h09;
    localparam logic [7:0] OPC_LD_A_BC   = 8'h0A;
    localparam logic [7:0] OPC_DEC_BC    = 8'h0B;
    localparam logic [7:0] OPC_INC_C     = 8'h0C;
    localparam logic [7:0] OPC_DEC_C     = 8'h0D;
    localparam logic [7:0] OPC_LD_C_N    = 8'h0E;
    localparam logic [7:0] OPC_RRCA      = 8'h0F;

    localparam logic [15:0] SP_RESET = 16'hFFFE;

    // flag bit positions
    localparam int FL_Z = 3;
    localparam int FL_N = 2;
    localparam int FL_H = 1;
    localparam int FL_C = 0;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LD_BC_NN,
        OP_ST_BC_A,
        OP_INC_BC,
        OP_INC_B,
        OP_DEC_B,
        OP_LD_B_N,
        OP_RLCA,
        OP_ST_NN_SP,
        OP_ADD_HL_BC,
        OP_LD_A_BC,
        OP_DEC_BC,
        OP_INC_C,
        OP_DEC_C,
        OP_LD_C_N,
        OP_RRCA
    } t_op;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] imm_low;
        logic [7:0] imm_high;
        logic [7:0] load_data;
    } t_in;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        last;
        logic [7:0]  out_a;
        logic [3:0]  out_flags;
        logic [15:0] out_bc;
        logic [15:0] out_hl;
        logic [15:0] out_pc;
    } t_out;

    // decoded instruction as it sits in the queue
    typedef struct packed {
        t_op         op;
        logic [1:0]  len;
        logic [15:0] nn;
        logic [7:0]  load_data;
    } t_uop;

endpackage

[rtl/core/lr35r0_front.sv]
// front end: takes instruction beats and decodes them into queue entries
`timescale 1ns / 1ps

module lr35r0_front (
    input  logic               i_in_valid,
    input  lr35r0_pkg::t_in    i_in_data,
    input  logic               i_q_ready,
    output logic               o_in_ready,
    output logic               o_push,
    output lr35r0_pkg::t_uop   o_uop
);

    always_comb begin
        o_uop.nn        = {i_in_data.imm_high, i_in_data.imm_low};
        o_uop.load_data = i_in_data.load_data;
        o_uop.len       = 2'd1;
        case (i_in_data.opcode)
            lr35r0_pkg::OPC_NOP:       o_uop.op = lr35r0_pkg::OP_NOP;
            lr35r0_pkg::OPC_LD_BC_NN: begin
                o_uop.op  = lr35r0_pkg::OP_LD_BC_NN;
                o_uop.len = 2'd3;
            end
            lr35r0_pkg::OPC_ST_BC_A:   o_uop.op = lr35r0_pkg::OP_ST_BC_A;
            lr35r0_pkg::OPC_INC_BC:    o_uop.op = lr35r0_pkg::OP_INC_BC;
            lr35r0_pkg::OPC_INC_B:     o_uop.op = lr35r0_pkg::OP_INC_B;
            lr35r0_pkg::OPC_DEC_B:     o_uop.op = lr35r0_pkg::OP_DEC_B;
            lr35r0_pkg::OPC_LD_B_N: begin
                o_uop.op  = lr35r0_pkg::OP_LD_B_N;
                o_uop.len = 2'd2;
            end
            lr35r0_pkg::OPC_RLCA:      o_uop.op = lr35r0_pkg::OP_RLCA;
            lr35r0_pkg::OPC_ST_NN_SP: begin
                o_uop.op  = lr35r0_pkg::OP_ST_NN_SP;
                o_uop.len = 2'd3;
            end
            lr35r0_pkg::OPC_ADD_HL_BC: o_uop.op = lr35r0_pkg::OP_ADD_HL_BC;
            lr35r0_pkg::OPC_LD_A_BC:   o_uop.op = lr35r0_pkg::OP_LD_A_BC;
            lr35r0_pkg::OPC_DEC_BC:    o_uop.op = lr35r0_pkg::OP_DEC_BC;
            lr35r0_pkg::OPC_INC_C:     o_uop.op = lr35r0_pkg::OP_INC_C;
            lr35r0_pkg::OPC_DEC_C:     o_uop.op = lr35r0_pkg::OP_DEC_C;
            lr35r0_pkg::OPC_LD_C_N: begin
                o_uop.op  = lr35r0_pkg::OP_LD_C_N;
                o_uop.len = 2'd2;
            end
            lr35r0_pkg::OPC_RRCA:      o_uop.op = lr35r0_pkg::OP_RRCA;
            // every other opcode, prefix byte included, only steps pc
            default:                   o_uop.op = lr35r0_pkg::OP_NOP;
        endcase
    end

    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid & i_q_ready;

endmodule

[rtl/core/lr35r0_queue.sv]
// small fifo of decoded instructions between front and back end
`timescale 1ns / 1ps

module lr35r0_queue #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lr35r0_pkg::t_uop   i_uop,
    output logic               o_ready,
    output logic               o_valid,
    output lr35r0_pkg::t_uop   o_uop,
    input  logic               i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_C = PW'(DEPTH - 1);

    lr35r0_pkg::t_uop r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_ready = (r_count != FULL_C);
    assign o_valid = (r_count != '0);
    assign o_uop   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_C) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_C) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_uop;
        end
    end

endmodule

[rtl/core/lr35r0_back.sv]
// back end: register file, execution and the output register
`timescale 1ns / 1ps

module lr35r0_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  lr35r0_pkg::t_uop   i_uop,
    output logic               o_pop,
    output logic               o_out_valid,
    output lr35r0_pkg::t_out   o_out_data,
    input  logic               i_out_ready
);

    logic [7:0]  r_acc;
    logic [3:0]  r_flags;
    logic [15:0] r_bc;
    logic [15:0] r_hl;
    logic [15:0] r_sp;
    logic [15:0] r_pc;
    logic        r_second;
    logic        r_out_valid;
    lr35r0_pkg::t_out r_out;
    logic [15:0] r_nn_next;

    logic [7:0]  n_acc;
    logic [3:0]  n_flags;
    logic [15:0] n_bc;
    logic [15:0] n_hl;
    logic [15:0] n_pc;

    logic        w_adv;
    logic [7:0]  w_inc_in;
    logic [7:0]  w_inc_res;
    logic [3:0]  w_inc_flags;
    logic [7:0]  w_dec_res;
    logic [3:0]  w_dec_flags;
    logic [16:0] w_add;
    logic [12:0] w_add_low;

    assign w_adv       = ~r_out_valid | i_out_ready;
    assign o_pop       = i_q_valid & w_adv & ~r_second;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // one shared 8-bit operand for the inc and dec, picked from B or C by opcode
    assign w_inc_in = (i_uop.op == lr35r0_pkg::OP_INC_B || i_uop.op == lr35r0_pkg::OP_DEC_B)
                      ? r_bc[15:8] : r_bc[7:0];
    assign w_inc_res = w_inc_in + 8'd1;
    assign w_dec_res = w_inc_in - 8'd1;

    always_comb begin
        w_inc_flags           = 4'b0;
        w_inc_flags[lr35r0_pkg::FL_Z] = (w_inc_res == 8'd0);
        w_inc_flags[lr35r0_pkg::FL_H] = (w_inc_in[3:0] == 4'hF);
        w_inc_flags[lr35r0_pkg::FL_C] = r_flags[lr35r0_pkg::FL_C];
        w_dec_flags           = 4'b0;
        w_dec_flags[lr35r0_pkg::FL_Z] = (w_dec_res == 8'd0);
        w_dec_flags[lr35r0_pkg::FL_N] = 1'b1;
        w_dec_flags[lr35r0_pkg::FL_H] = (w_inc_in[3:0] == 4'h0);
        w_dec_flags[lr35r0_pkg::FL_C] = r_flags[lr35r0_pkg::FL_C];
    end

    assign w_add     = {1'b0, r_hl} + {1'b0, r_bc};
    assign w_add_low = {1'b0, r_hl[11:0]} + {1'b0, r_bc[11:0]};

    always_comb begin
        n_acc   = r_acc;
        n_flags = r_flags;
        n_bc    = r_bc;
        n_hl    = r_hl;
        n_pc    = r_pc + {14'd0, i_uop.len};
        case (i_uop.op)
            lr35r0_pkg::OP_LD_BC_NN: n_bc = i_uop.nn;
            lr35r0_pkg::OP_INC_BC:   n_bc = r_bc + 16'd1;
            lr35r0_pkg::OP_DEC_BC:   n_bc = r_bc - 16'd1;
            lr35r0_pkg::OP_INC_B: begin
                n_bc    = {w_inc_res, r_bc[7:0]};
                n_flags = w_inc_flags;
            end
            lr35r0_pkg::OP_DEC_B: begin
                n_bc    = {w_dec_res, r_bc[7:0]};
                n_flags = w_dec_flags;
            end
            lr35r0_pkg::OP_INC_C: begin
                n_bc    = {r_bc[15:8], w_inc_res};
                n_flags = w_inc_flags;
            end
            lr35r0_pkg::OP_DEC_C: begin
                n_bc    = {r_bc[15:8], w_dec_res};
                n_flags = w_dec_flags;
            end
            lr35r0_pkg::OP_LD_B_N:   n_bc = {i_uop.nn[7:0], r_bc[7:0]};
            lr35r0_pkg::OP_LD_C_N:   n_bc = {r_bc[15:8], i_uop.nn[7:0]};
            lr35r0_pkg::OP_RLCA: begin
                n_acc   = {r_acc[6:0], r_acc[7]};
                n_flags = {3'b000, r_acc[7]};
            end
            lr35r0_pkg::OP_RRCA: begin
                n_acc   = {r_acc[0], r_acc[7:1]};
                n_flags = {3'b000, r_acc[0]};
            end
            lr35r0_pkg::OP_ADD_HL_BC: begin
                n_hl    = w_add[15:0];
                n_flags = {r_flags[lr35r0_pkg::FL_Z], 1'b0, w_add_low[12], w_add[16]};
            end
            lr35r0_pkg::OP_LD_A_BC:  n_acc = i_uop.load_data;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 8'd0;
            r_flags     <= 4'd0;
            r_bc        <= 16'd0;
            r_hl        <= 16'd0;
            r_sp        <= lr35r0_pkg::SP_RESET;
            r_pc        <= 16'd0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_acc       <= n_acc;
            r_flags     <= n_flags;
            r_bc        <= n_bc;
            r_hl        <= n_hl;
            r_pc        <= n_pc;
            r_second    <= (i_uop.op == lr35r0_pkg::OP_ST_NN_SP);
            r_out_valid <= 1'b1;
        end else if (r_second && w_adv) begin
            r_second    <= 1'b0;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.out_a     <= n_acc;
            r_out.out_flags <= n_flags;
            r_out.out_bc    <= n_bc;
            r_out.out_hl    <= n_hl;
            r_out.out_pc    <= n_pc;
            r_nn_next       <= i_uop.nn + 16'd1;
            case (i_uop.op)
                lr35r0_pkg::OP_ST_BC_A: begin
                    r_out.write_enable  <= 1'b1;
                    r_out.write_address <= r_bc;
                    r_out.write_data    <= r_acc;
                    r_out.last          <= 1'b1;
                end
                lr35r0_pkg::OP_ST_NN_SP: begin
                    // low byte now, high byte on the following beat
                    r_out.write_enable  <= 1'b1;
                    r_out.write_address <= i_uop.nn;
                    r_out.write_data    <= r_sp[7:0];
                    r_out.last          <= 1'b0;
                end
                default: begin
                    r_out.write_enable  <= 1'b0;
                    r_out.write_address <= 16'd0;
                    r_out.write_data    <= 8'd0;
                    r_out.last          <= 1'b1;
                end
            endcase
        end else if (r_second && w_adv) begin
            r_out.write_address <= r_nn_next;
            r_out.write_data    <= r_sp[15:8];
            r_out.last          <= 1'b1;
        end
    end

endmodule

[rtl/core/lr35902_opcode_row0_executor.sv]
// top level of the row-0 instruction executor: front end, queue and back end
`timescale 1ns / 1ps

// Executes Game Boy CPU opcodes 0x00-0x0F (all other opcodes step PC by one) and
// returns the register state after each instruction, plus any memory byte writes.
// An instruction beat is decoded by the front end and lands in a short queue on the
// clock it is taken; the back end then executes it from the queue and loads the
// output register with its result. The block takes a new instruction every cycle
// while the queue has room, and gives one result beat per cycle while the output is
// not stalled, for every opcode except LD (nn),SP, which yields two beats (low byte,
// then high byte with last set) and so occupies the back end for both beats.
// Sustained rate is set by the single output register of the back end. The queue
// lets the input keep flowing while the output is stalled, until the queue fills.
`include "lr35902_opcode_row0_executor_macros.svh"

module lr35902_opcode_row0_executor #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lr35r0_pkg::t_in    i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lr35r0_pkg::t_out   o_out_data
);

    logic             w_push;
    logic             w_q_ready;
    logic             w_q_valid;
    logic             w_pop;
    lr35r0_pkg::t_uop w_uop_in;
    lr35r0_pkg::t_uop w_uop_out;

    lr35r0_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_ready  (w_q_ready),
        .o_in_ready (o_in_ready),
        .o_push     (w_push),
        .o_uop      (w_uop_in)
    );

    lr35r0_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_uop   (w_uop_in),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_uop   (w_uop_out),
        .i_pop   (w_pop)
    );

    lr35r0_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_uop       (w_uop_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

    // an accepted instruction is waiting in the queue on the next clock
    `LR_ASSERT_NEXT(a_accept_queued, i_in_valid && o_in_ready, w_q_valid, "accepted beat lost")

    // a non-final result is always the first half of a memory write pair
    `LR_ASSERT_NOW(a_nonlast_writes, o_out_valid && !o_out_data.last, o_out_data.write_enable, "non-final beat without write")

    // the second write beat follows straight after the first is taken
    `LR_ASSERT_NEXT(a_pair_follows, o_out_valid && i_out_ready && !o_out_data.last, o_out_valid && o_out_data.last && o_out_data.write_enable, "second write beat missing")

endmodule

[dv/tb_top.sv]
// testbench for the row-0 instruction executor: directed, random and stall tests
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int IDLE_PERCENT   = 23;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             in_valid  = 1'b0;
    lr35r0_pkg::t_in  in_data   = '0;
    logic             out_ready = 1'b0;
    logic             in_ready;
    logic             out_valid;
    lr35r0_pkg::t_out out_data;

    // architectural state as the predictor sees it
    logic [7:0]  reg_a;
    logic [3:0]  reg_f;
    logic [15:0] reg_bc;
    logic [15:0] reg_hl;
    logic [15:0] reg_sp;
    logic [15:0] reg_pc;

    lr35r0_pkg::t_out pending_beats[$];
    int   error_count = 0;
    bit   idle_on     = 1'b1;
    int   hold_asked  = 0;
    int   hold_done   = 0;
    int   hold_left   = 0;
    int   quiet_cycles = 0;

    lr35902_opcode_row0_executor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // inc/dec of an 8-bit register, carry left alone
    function automatic logic [7:0] bump8(input logic [7:0] v, input bit down);
        logic [7:0] r;
        r = down ? v - 8'd1 : v + 8'd1;
        reg_f[lr35r0_pkg::FL_Z] = (r == 8'd0);
        reg_f[lr35r0_pkg::FL_N] = down;
        reg_f[lr35r0_pkg::FL_H] = down ? (v[3:0] == 4'h0) : (v[3:0] == 4'hF);
        return r;
    endfunction

    function automatic lr35r0_pkg::t_in instr(input logic [7:0] op, input logic [7:0] lo,
                                              input logic [7:0] hi, input logic [7:0] ld);
        lr35r0_pkg::t_in d;
        d.opcode    = op;
        d.imm_low   = lo;
        d.imm_high  = hi;
        d.load_data = ld;
        return d;
    endfunction

    // executes one instruction on the predicted state and queues its beats
    task automatic exec_instr(input lr35r0_pkg::t_in ins);
        logic [15:0] nn;
        logic [16:0] sum16;
        logic [12:0] sum12;
        logic [15:0] len;
        lr35r0_pkg::t_out beat;
        nn   = {ins.imm_high, ins.imm_low};
        len  = 16'd1;
        beat = '0;
        beat.last = 1'b1;
        case (ins.opcode)
            lr35r0_pkg::OPC_LD_BC_NN: begin
                reg_bc = nn;
                len    = 16'd3;
            end
            lr35r0_pkg::OPC_ST_BC_A: begin
                beat.write_enable  = 1'b1;
                beat.write_address = reg_bc;
                beat.write_data    = reg_a;
            end
            lr35r0_pkg::OPC_INC_BC:  reg_bc = reg_bc + 16'd1;
            lr35r0_pkg::OPC_INC_B:   reg_bc[15:8] = bump8(reg_bc[15:8], 1'b0);
            lr35r0_pkg::OPC_DEC_B:   reg_bc[15:8] = bump8(reg_bc[15:8], 1'b1);
            lr35r0_pkg::OPC_LD_B_N: begin
                reg_bc[15:8] = ins.imm_low;
                len          = 16'd2;
            end
            lr35r0_pkg::OPC_RLCA: begin
                reg_f = {3'b000, reg_a[7]};
                reg_a = {reg_a[6:0], reg_a[7]};
            end
            lr35r0_pkg::OPC_ST_NN_SP: begin
                len = 16'd3;
                beat.write_enable  = 1'b1;
                beat.write_address = nn;
                beat.write_data    = reg_sp[7:0];
                beat.last          = 1'b0;
            end
            lr35r0_pkg::OPC_ADD_HL_BC: begin
                sum12 = {1'b0, reg_hl[11:0]} + {1'b0, reg_bc[11:0]};
                sum16 = {1'b0, reg_hl} + {1'b0, reg_bc};
                reg_f[lr35r0_pkg::FL_N] = 1'b0;
                reg_f[lr35r0_pkg::FL_H] = sum12[12];
                reg_f[lr35r0_pkg::FL_C] = sum16[16];
                reg_hl = sum16[15:0];
            end
            lr35r0_pkg::OPC_LD_A_BC: reg_a = ins.load_data;
            lr35r0_pkg::OPC_DEC_BC:  reg_bc = reg_bc - 16'd1;
            lr35r0_pkg::OPC_INC_C:   reg_bc[7:0] = bump8(reg_bc[7:0], 1'b0);
            lr35r0_pkg::OPC_DEC_C:   reg_bc[7:0] = bump8(reg_bc[7:0], 1'b1);
            lr35r0_pkg::OPC_LD_C_N: begin
                reg_bc[7:0] = ins.imm_low;
                len         = 16'd2;
            end
            lr35r0_pkg::OPC_RRCA: begin
                reg_f = {3'b000, reg_a[0]};
                reg_a = {reg_a[0], reg_a[7:1]};
            end
            default: ;
        endcase
        reg_pc = reg_pc + len;
        beat.out_a     = reg_a;
        beat.out_flags = reg_f;
        beat.out_bc    = reg_bc;
        beat.out_hl    = reg_hl;
        beat.out_pc    = reg_pc;
        pending_beats.push_back(beat);
        if (ins.opcode == lr35r0_pkg::OPC_ST_NN_SP) begin
            // high byte of sp goes to nn+1, address wraps
            beat.write_address = nn + 16'd1;
            beat.write_data    = reg_sp[15:8];
            beat.last          = 1'b1;
            pending_beats.push_back(beat);
        end
    endtask

    // offers one instruction beat and waits for it to be taken
    task automatic send_instr(input lr35r0_pkg::t_in ins);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= ins;
        do @(posedge i_clk); while (!in_ready);
        exec_instr(ins);
    endtask

    task automatic send_random(input int pct_row0);
        lr35r0_pkg::t_in ins;
        ins.opcode    = ($urandom_range(99) < pct_row0) ? 8'($urandom_range(15))
                                                        : 8'($urandom_range(255));
        ins.imm_low   = 8'($urandom_range(255));
        ins.imm_high  = 8'($urandom_range(255));
        ins.load_data = 8'($urandom_range(255));
        send_instr(ins);
    endtask

    task automatic test_every_opcode();
        for (int op = 0; op < 16; op++) begin
            if (op[0])
                send_instr(instr(8'(op), 8'hFF, 8'hFF, 8'hFF));
            else
                send_instr(instr(8'(op), 8'h00, 8'h00, 8'h00));
        end
        send_instr(instr(8'hCB, 8'hA5, 8'h5A, 8'hFF));
        send_instr(instr(8'hFF, 8'h00, 8'hFF, 8'h00));
    endtask

    task automatic test_flag_edges();
        send_instr(instr(lr35r0_pkg::OPC_LD_B_N, 8'hFF, 8'h00, 8'h00));
        send_instr(instr(lr35r0_pkg::OPC_INC_B, 8'h00, 8'h00, 8'h00)); // wraps to zero, half carry
        send_instr(instr(lr35r0_pkg::OPC_DEC_B, 8'h00, 8'h00, 8'h00)); // borrow from low nibble
        send_instr(instr(lr35r0_pkg::OPC_LD_C_N, 8'h01, 8'h00, 8'h00));
        send_instr(instr(lr35r0_pkg::OPC_DEC_C, 8'h00, 8'h00, 8'h00)); // result zero
        send_instr(instr(lr35r0_pkg::OPC_LD_A_BC, 8'h00, 8'h00, 8'h81));
        send_instr(instr(lr35r0_pkg::OPC_RLCA, 8'h00, 8'h00, 8'h00));
        send_instr(instr(lr35r0_pkg::OPC_RRCA, 8'h00, 8'h00, 8'h00));
        send_instr(instr(lr35r0_pkg::OPC_LD_BC_NN, 8'hFF, 8'h8F, 8'h00));
        send_instr(instr(lr35r0_pkg::OPC_ADD_HL_BC, 8'h00, 8'h00, 8'h00));
        send_instr(instr(lr35r0_pkg::OPC_ADD_HL_BC, 8'h00, 8'h00, 8'h00));
        send_instr(instr(lr35r0_pkg::OPC_ST_NN_SP, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic test_random_stream(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            // a stretch with no idling on either side
            idle_on = !(i >= n_items / 3 && i < n_items / 2);
            send_random(75);
        end
        idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        hold_asked++;
        for (int i = 0; i < 30; i++)
            send_random(90);
    endtask

    task automatic compare_field(input string name, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        lr35r0_pkg::t_out exp_beat;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, out_data);
                error_count++;
            end else begin
                exp_beat = pending_beats.pop_front();
                compare_field("write_enable", 16'(exp_beat.write_enable),
                              16'(out_data.write_enable));
                compare_field("write_address", exp_beat.write_address,
                              out_data.write_address);
                compare_field("write_data", 16'(exp_beat.write_data), 16'(out_data.write_data));
                compare_field("last", 16'(exp_beat.last), 16'(out_data.last));
                compare_field("out_a", 16'(exp_beat.out_a), 16'(out_data.out_a));
                compare_field("out_flags", 16'(exp_beat.out_flags), 16'(out_data.out_flags));
                compare_field("out_bc", exp_beat.out_bc, out_data.out_bc);
                compare_field("out_hl", exp_beat.out_hl, out_data.out_hl);
                compare_field("out_pc", exp_beat.out_pc, out_data.out_pc);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_done != hold_asked) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_asked;
        end else begin
            out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        reg_a  = 8'h00;
        reg_f  = 4'h0;
        reg_bc = 16'h0000;
        reg_hl = 16'h0000;
        reg_sp = lr35r0_pkg::SP_RESET;
        reg_pc = 16'h0000;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_every_opcode();
        test_flag_edges();
        test_random_stream(600);
        test_output_stall();

        // last beat was taken at this edge, drop valid before the next one
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
